// File: src/tgpr_pkg.sv
`timescale 1ns / 1ps

package tgpr_pkg;

  localparam int CODE_W      = 7;
  localparam int COLOR_W     = 8;
  localparam int INDEX_W     = 16;
  localparam int GLYPH_DIM   = 8;
  localparam int GLYPH_BITS  = GLYPH_DIM * GLYPH_DIM;
  localparam int Y_W         = $clog2(GLYPH_DIM);
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_TEXT_COLUMNS = 40;
  localparam int DEF_TEXT_ROWS    = 25;
  localparam int DEF_FRAME_WIDTH  = 320;
  localparam int DEF_GLYPH_COUNT  = 128;

  localparam logic [CODE_W-1:0] CODE_CR = 7'd13;
  localparam logic [CODE_W-1:0] CODE_LF = 7'd10;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  // One glyph to draw: set bits in scan order, top-left pixel offset, color.
  typedef struct packed {
    logic [GLYPH_BITS-1:0] glyph;
    logic [INDEX_W-1:0]    col_base;
    logic [COLOR_W-1:0]    color;
  } draw_entry_t;

  // Font image, glyph row 0 in the low byte, bit x is pixel x.
  function automatic logic [GLYPH_BITS-1:0] glyph_rows(input logic [CODE_W-1:0] code);
    logic [GLYPH_BITS-1:0] rows;
    unique case (code)
      7'd33:  rows = 64'h0018_0018_183C_3C18;
      7'd34:  rows = 64'h0000_0000_0000_3636;
      7'd35:  rows = 64'h0036_367F_367F_3636;
      7'd36:  rows = 64'h000C_1F30_1E03_3E0C;
      7'd37:  rows = 64'h0063_660C_1833_6300;
      7'd38:  rows = 64'h006E_333B_6E1C_361C;
      7'd39:  rows = 64'h0000_0000_0003_0606;
      7'd40:  rows = 64'h0018_0C06_0606_0C18;
      7'd41:  rows = 64'h0006_0C18_1818_0C06;
      7'd42:  rows = 64'h0000_663C_FF3C_6600;
      7'd43:  rows = 64'h0000_0C0C_3F0C_0C00;
      7'd44:  rows = 64'h060C_0C00_0000_0000;
      7'd45:  rows = 64'h0000_0000_3F00_0000;
      7'd46:  rows = 64'h000C_0C00_0000_0000;
      7'd47:  rows = 64'h0001_0306_0C18_3060;
      7'd48:  rows = 64'h003E_676F_7B73_633E;
      7'd49:  rows = 64'h003F_0C0C_0C0C_0E0C;
      7'd50:  rows = 64'h003F_3306_1C30_331E;
      7'd51:  rows = 64'h001E_3330_1C30_331E;
      7'd52:  rows = 64'h0078_307F_3336_3C38;
      7'd53:  rows = 64'h001E_3330_301F_033F;
      7'd54:  rows = 64'h001E_3333_1F03_061C;
      7'd55:  rows = 64'h000C_0C0C_1830_333F;
      7'd56:  rows = 64'h001E_3333_1E33_331E;
      7'd57:  rows = 64'h000E_1830_3E33_331E;
      7'd58:  rows = 64'h000C_0C00_000C_0C00;
      7'd59:  rows = 64'h060C_0C00_000C_0C00;
      7'd60:  rows = 64'h0018_0C06_0306_0C18;
      7'd61:  rows = 64'h0000_3F00_003F_0000;
      7'd62:  rows = 64'h0006_0C18_3018_0C06;
      7'd63:  rows = 64'h000C_000C_1830_331E;
      7'd64:  rows = 64'h001E_037B_7B7B_633E;
      7'd65:  rows = 64'h0033_333F_3333_1E0C;
      7'd66:  rows = 64'h003F_6666_3E66_663F;
      7'd67:  rows = 64'h003C_6603_0303_663C;
      7'd68:  rows = 64'h001F_3666_6666_361F;
      7'd69:  rows = 64'h007F_4616_1E16_467F;
      7'd70:  rows = 64'h000F_0616_1E16_467F;
      7'd71:  rows = 64'h007C_6673_0303_663C;
      7'd72:  rows = 64'h0033_3333_3F33_3333;
      7'd73:  rows = 64'h001E_0C0C_0C0C_0C1E;
      7'd74:  rows = 64'h001E_3333_3030_3078;
      7'd75:  rows = 64'h0067_6636_1E36_6667;
      7'd76:  rows = 64'h007F_6646_0606_060F;
      7'd77:  rows = 64'h0063_636B_7F7F_7763;
      7'd78:  rows = 64'h0063_6373_7B6F_6763;
      7'd79:  rows = 64'h001C_3663_6363_361C;
      7'd80:  rows = 64'h000F_0606_3E66_663F;
      7'd81:  rows = 64'h0038_1E3B_3333_331E;
      7'd82:  rows = 64'h0067_6636_3E66_663F;
      7'd83:  rows = 64'h001E_3338_0E07_331E;
      7'd84:  rows = 64'h001E_0C0C_0C0C_2D3F;
      7'd85:  rows = 64'h003F_3333_3333_3333;
      7'd86:  rows = 64'h000C_1E33_3333_3333;
      7'd87:  rows = 64'h0063_777F_6B63_6363;
      7'd88:  rows = 64'h0063_361C_1C36_6363;
      7'd89:  rows = 64'h001E_0C0C_1E33_3333;
      7'd90:  rows = 64'h007F_664C_1831_637F;
      7'd91:  rows = 64'h001E_0606_0606_061E;
      7'd92:  rows = 64'h0040_6030_180C_0603;
      7'd93:  rows = 64'h001E_1818_1818_181E;
      7'd94:  rows = 64'h0000_0000_6336_1C08;
      7'd95:  rows = 64'hFF00_0000_0000_0000;
      7'd96:  rows = 64'h0000_0000_0018_0C0C;
      7'd97:  rows = 64'h006E_333E_301E_0000;
      7'd98:  rows = 64'h003B_6666_3E06_0607;
      7'd99:  rows = 64'h001E_3303_331E_0000;
      7'd100: rows = 64'h006E_3333_3E30_3038;
      7'd101: rows = 64'h001E_033F_331E_0000;
      7'd102: rows = 64'h000F_0606_0F06_361C;
      7'd103: rows = 64'h1F30_3E33_336E_0000;
      7'd104: rows = 64'h0067_6666_6E36_0607;
      7'd105: rows = 64'h001E_0C0C_0C0E_000C;
      7'd106: rows = 64'h1E33_3330_3030_0030;
      7'd107: rows = 64'h0067_361E_3666_0607;
      7'd108: rows = 64'h001E_0C0C_0C0C_0C0E;
      7'd109: rows = 64'h0063_6B7F_7F33_0000;
      7'd110: rows = 64'h0033_3333_331F_0000;
      7'd111: rows = 64'h001E_3333_331E_0000;
      7'd112: rows = 64'h0F06_3E66_663B_0000;
      7'd113: rows = 64'h7830_3E33_336E_0000;
      7'd114: rows = 64'h000F_0666_6E3B_0000;
      7'd115: rows = 64'h001F_301E_033E_0000;
      7'd116: rows = 64'h0018_2C0C_0C3E_0C08;
      7'd117: rows = 64'h006E_3333_3333_0000;
      7'd118: rows = 64'h000C_1E33_3333_0000;
      7'd119: rows = 64'h0036_7F7F_6B63_0000;
      7'd120: rows = 64'h0063_361C_3663_0000;
      7'd121: rows = 64'h1F30_3E33_3333_0000;
      7'd122: rows = 64'h003F_260C_193F_0000;
      7'd123: rows = 64'h0038_0C0C_070C_0C38;
      7'd124: rows = 64'h0018_1818_0018_1818;
      7'd125: rows = 64'h0007_0C0C_380C_0C07;
      7'd126: rows = 64'h0000_0000_0000_3B6E;
      default: rows = '0;
    endcase
    return rows;
  endfunction

  // Reorder rows into scan order: column x outer, glyph row y inner.
  function automatic logic [GLYPH_BITS-1:0] glyph_scan(input logic [GLYPH_BITS-1:0] rows);
    logic [GLYPH_BITS-1:0] scan;
    for (int x = 0; x < GLYPH_DIM; x++) begin
      for (int y = 0; y < GLYPH_DIM; y++) begin
        scan[x*GLYPH_DIM + y] = rows[y*GLYPH_DIM + x];
      end
    end
    return scan;
  endfunction

endpackage

// File: src/tgpr_in_if.sv
`timescale 1ns / 1ps

interface tgpr_in_if
  import tgpr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_code;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, output char_code, output pixel_color, input ready);
  modport sink   (input valid, input char_code, input pixel_color, output ready);
endinterface

// File: src/tgpr_out_if.sv
`timescale 1ns / 1ps

interface tgpr_out_if
  import tgpr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic [COLOR_W-1:0] pixel_value;
  logic               last_write;

  modport source (output valid, output pixel_index, output pixel_value, output last_write,
                  input ready);
  modport sink   (input valid, input pixel_index, input pixel_value, input last_write,
                  output ready);
endinterface

// File: src/tgpr_front.sv
`timescale 1ns / 1ps

module tgpr_front
  import tgpr_pkg::*;
#(
  parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
  parameter int TEXT_ROWS    = DEF_TEXT_ROWS,
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  tgpr_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        push,
  output draw_entry_t push_entry
);

  localparam int COL_W      = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
  localparam int ROW_W      = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
  localparam int ROW_STRIDE = FRAME_WIDTH * GLYPH_DIM;

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  accept;
  logic                  is_cr, is_lf;
  logic [GLYPH_BITS-1:0] glyph;
  logic [INDEX_W-1:0]    row_ext, col_ext;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_cr       = (in_ch.char_code == CODE_CR);
  assign is_lf       = (in_ch.char_code == CODE_LF);

  // Codes past the font count draw blank.
  assign glyph = (int'(in_ch.char_code) < GLYPH_COUNT) ?
                 glyph_scan(glyph_rows(in_ch.char_code)) : '0;

  assign row_ext = INDEX_W'(row_r);
  assign col_ext = INDEX_W'(col_r);

  assign push_entry.glyph    = glyph;
  assign push_entry.col_base = row_ext * INDEX_W'(ROW_STRIDE) + (col_ext << Y_W);
  assign push_entry.color    = in_ch.pixel_color;

  // Blank glyphs and control codes only move the cursor.
  assign push = accept && !is_cr && !is_lf && (glyph != '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (is_cr) begin
        col_nxt = '0;
      end else if (is_lf) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(TEXT_ROWS - 1)) ? '0 : row_r + 1'b1;
      end else if (col_r == COL_W'(TEXT_COLUMNS - 1)) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(TEXT_ROWS - 1)) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: src/tgpr_queue.sv
`timescale 1ns / 1ps

module tgpr_queue
  import tgpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  draw_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output draw_entry_t q_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  draw_entry_t      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// File: src/tgpr_back.sv
`timescale 1ns / 1ps

module tgpr_back
  import tgpr_pkg::*;
#(
  parameter int FRAME_WIDTH = DEF_FRAME_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  draw_entry_t q_entry,
  output logic        pop,
  tgpr_out_if.source  out_ch
);

  back_state_t           state_r, state_nxt;
  logic [GLYPH_BITS-1:0] bits_r;
  logic [INDEX_W-1:0]    col_base_r, yoff_r;
  logic [Y_W-1:0]        y_r;
  logic [COLOR_W-1:0]    color_r;
  logic                  out_valid_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic [COLOR_W-1:0]    out_value_r;
  logic                  out_last_r;
  logic                  step;
  logic                  rest_empty;

  assign rest_empty = (bits_r[GLYPH_BITS-1:1] == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_SCAN;
      BK_SCAN: if (step && rest_empty) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    step = 1'b0;
    unique case (state_r)
      BK_IDLE: pop  = q_valid;
      BK_SCAN: step = !out_valid_r || out_ch.ready;
      default: begin
        pop  = 1'b0;
        step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (step) begin
        out_valid_r <= bits_r[0];
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan position: y counts down the glyph column, col_base moves one pixel right per column.
  always_ff @(posedge clk) begin
    if (pop) begin
      bits_r     <= q_entry.glyph;
      col_base_r <= q_entry.col_base;
      color_r    <= q_entry.color;
      yoff_r     <= '0;
      y_r        <= '0;
    end else if (step) begin
      bits_r <= bits_r >> 1;
      y_r    <= y_r + 1'b1;
      if (y_r == Y_W'(GLYPH_DIM - 1)) begin
        yoff_r     <= '0;
        col_base_r <= col_base_r + 1'b1;
      end else begin
        yoff_r <= yoff_r + INDEX_W'(FRAME_WIDTH);
      end
    end
    if (step && bits_r[0]) begin
      out_index_r <= col_base_r + yoff_r;
      out_value_r <= color_r;
      out_last_r  <= rest_empty;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_index = out_index_r;
  assign out_ch.pixel_value = out_value_r;
  assign out_ch.last_write  = out_last_r;

  a_scan_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SCAN |-> bits_r != '0)
    else $error("scan running with no pixels left");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && rest_empty |=> state_r == BK_IDLE)
    else $error("scan did not stop after its last pixel");

  a_pop_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == BK_SCAN)
    else $error("entry taken without starting a scan");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && bits_r[0] && rest_empty |=> out_valid_r && out_last_r)
    else $error("final pixel not marked as last");

endmodule

// File: src/text_glyph_pixel_renderer.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload                                   Handshake
// in_ch    sink       char_code[6:0], pixel_color[7:0]          valid/ready
// out_ch   source     pixel_index[15:0], pixel_value[7:0],      valid/ready
//                     last_write
//
// A character is taken while the two-entry draw queue has room;
// carriage return, line feed and blank glyphs finish there.
// The single pixel scanner in the back end loads a drawn glyph, steps up to its
// last set pixel (at most 64 positions) and takes the next glyph once it is done.
// Reset clears the cursor, the queue and the scanner; the font is constant.
// Output stalls hold the scanner; a full queue drops in_ch.ready.

module text_glyph_pixel_renderer
  import tgpr_pkg::*;
#(
  parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
  parameter int TEXT_ROWS    = DEF_TEXT_ROWS,
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  tgpr_in_if.sink    in_ch,
  tgpr_out_if.source out_ch
);

  logic        push, pop, q_full, q_valid;
  draw_entry_t push_entry, q_entry;

  tgpr_front #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tgpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  tgpr_back #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
